### hdl/itoa_pkg.sv
// package for the integer to ascii formatter
// types, constants and digit helpers; no dependencies
package itoa_pkg;

  localparam int unsigned MaxPrecisionDef = 32;
  localparam int unsigned ValueW = 64;
  localparam int unsigned NumCells = 22;  // enough digits for 64-bit octal

  localparam logic [1:0] BaseDec  = 2'd0;
  localparam logic [1:0] BaseOct  = 2'd1;
  localparam logic [1:0] BaseHex  = 2'd2;
  localparam logic [1:0] BaseRsvd = 2'd3;  // unused code, treated as decimal

  localparam logic [7:0] ChMinus  = 8'h2d;
  localparam logic [7:0] ChPlus   = 8'h2b;
  localparam logic [7:0] ChBlank  = 8'h20;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChX      = 8'h78;
  localparam logic [7:0] ChUpperA = 8'h41;
  localparam logic [7:0] ChLowerA = 8'h61;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CONV, ST_ALIGN, ST_SIGN, ST_PFX0, ST_PFXX, ST_PAD, ST_DIGIT
  } state_t;

  // ascii for one digit value
  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] r;
    if (d < 4'd10) r = ChZero + {4'd0, d};
    else if (upper) r = ChUpperA + {4'd0, d} - 8'd10;
    else r = ChLowerA + {4'd0, d} - 8'd10;
    return r;
  endfunction

endpackage

### hdl/itoa_cell.sv
// one digit cell of the conversion chain
// no dependencies
module itoa_cell (
  input  logic       clk,
  input  logic       clear,
  input  logic       bit_shift,
  input  logic       digit_shift,
  input  logic       dec_mode,
  input  logic       oct_mode,
  input  logic       bit_in,
  input  logic [3:0] digit_in,
  output logic [3:0] digit,
  output logic       carry_out
);

  logic [3:0] adj;

  // decimal digits of 5 and up get 3 added so the doubling carries at ten
  assign adj       = (dec_mode && digit >= 4'd5) ? digit + 4'd3 : digit;
  assign carry_out = oct_mode ? adj[2] : adj[3];

  always_ff @(posedge clk) begin
    if (clear) begin
      digit <= 4'd0;
    end else if (bit_shift) begin
      digit <= oct_mode ? {1'b0, adj[1:0], bit_in} : {adj[2:0], bit_in};
    end else if (digit_shift) begin
      digit <= digit_in;
    end
  end
endmodule

### hdl/itoa_divider.sv
// front end of the conversion: holds the magnitude and shifts it into the
// digit chain one bit per cycle, most significant first; depends on itoa_pkg
module itoa_divider (
  input  logic                        clk,
  input  logic                        load,
  input  logic                        shift,
  input  logic [itoa_pkg::ValueW-1:0] load_value,
  output logic                        bit_out,
  output logic                        last_bit
);
  import itoa_pkg::*;

  localparam int unsigned CntW = $clog2(ValueW);

  logic [ValueW-1:0] sreg;
  logic [CntW-1:0]   cnt;

  always_ff @(posedge clk) begin
    if (load) begin
      sreg <= load_value;
      cnt  <= '0;
    end else if (shift) begin
      sreg <= {sreg[ValueW-2:0], 1'b0};
      cnt  <= cnt + 1'b1;
    end
  end

  assign bit_out  = sreg[ValueW-1];
  assign last_bit = (cnt == CntW'(ValueW - 1));
endmodule

### hdl/integer_to_ascii_formatter.sv
// integer to ascii formatter, top level
// depends on itoa_pkg, itoa_divider, itoa_cell
//
// One transaction on the slave side carries a 64-bit value with its format
// options; the master side then returns the characters of the formatted
// number, most significant first, tlast on the final one. The magnitude is
// shifted into a row of 22 digit cells one bit per cycle; in decimal every
// cell adds 3 to a digit of 5 or more before each shift, in hex the cells
// are plain 4-bit groups and in octal 3-bit groups. The row is then shifted
// by whole digits to drop leading zeros (at least one digit kept), and the
// output walks the sign, the prefix, the zero pads and the digits at one
// character per cycle while the receiver accepts them. One item is worked
// on at a time: the slave side is ready only while idle, which may overlap
// the wait of the final character in the output register.
module integer_to_ascii_formatter #(
  parameter int unsigned MAX_PRECISION = itoa_pkg::MaxPrecisionDef
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // value[63:0], wide_mode[64], is_signed[65], base_select[67:66],
  // upper_case[68], alt_prefix[69], show_plus[70], plus_as_blank[71],
  // min_digits[77:72], zero fill to 80
  input  logic [79:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // char_out[7:0]
  output logic [7:0]  m_tdata,
  // last_char
  output logic        m_tlast
);
  import itoa_pkg::*;

  state_t state, state_next;
  state_t after_sign, after_pfx;

  // captured options
  logic [1:0]  bsel;
  logic        upper, alt, nonzero;
  logic [7:0]  sign_ch;
  logic        has_sign;
  logic [5:0]  prec;
  logic [4:0]  ndig;       // digits left in the row
  logic [5:0]  pads;
  logic [5:0]  need;       // sign plus digits

  // input decode
  logic [ValueW-1:0] in_val, in_mag;
  logic        in_wide, in_signed, in_neg;
  logic [1:0]  in_bsel;
  logic [5:0]  in_prec;
  logic        in_dec;

  assign in_wide   = s_tdata[64];
  assign in_signed = s_tdata[65];
  assign in_bsel   = (s_tdata[67:66] == BaseRsvd) ? BaseDec : s_tdata[67:66];
  assign in_dec    = (in_bsel == BaseDec);
  assign in_val    = in_wide ? s_tdata[63:0] : {32'd0, s_tdata[31:0]};
  assign in_neg    = in_signed && (in_wide ? in_val[63] : in_val[31]);
  always_comb begin
    in_mag = in_val;
    if (in_neg) begin
      in_mag = ~in_val + 64'd1;
      if (!in_wide) in_mag[63:32] = 32'd0;
    end
  end
  assign in_prec = (s_tdata[77:72] > 6'(MAX_PRECISION)) ? 6'(MAX_PRECISION)
                                                         : s_tdata[77:72];

  // control strobes
  logic feed_load, feed_shift, feed_bit, feed_last;
  logic chain_clear, bit_shift, digit_shift;
  logic out_free;
  logic m_load;
  logic [7:0] m_char;
  logic m_last;

  // bit feed
  itoa_divider u_feed (
    .clk(clk), .load(feed_load), .shift(feed_shift), .load_value(in_mag),
    .bit_out(feed_bit), .last_bit(feed_last)
  );

  // digit chain: cell 0 is the least significant end, the top cell is read
  logic [3:0] cell_d [NumCells];
  logic       cell_c [NumCells];
  logic [3:0] cell_top;
  logic       dec_mode, oct_mode;

  assign dec_mode = (bsel == BaseDec);
  assign oct_mode = (bsel == BaseOct);

  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    logic       b_in;
    logic [3:0] d_in;
    if (i == 0) begin : g_low
      assign b_in = feed_bit;
      assign d_in = 4'd0;
    end else begin : g_up
      assign b_in = cell_c[i-1];
      assign d_in = cell_d[i-1];
    end
    itoa_cell u_cell (
      .clk(clk), .clear(chain_clear), .bit_shift(bit_shift),
      .digit_shift(digit_shift), .dec_mode(dec_mode), .oct_mode(oct_mode),
      .bit_in(b_in), .digit_in(d_in), .digit(cell_d[i]), .carry_out(cell_c[i])
    );
  end

  assign cell_top = cell_d[NumCells-1];

  // output sequencing
  assign out_free   = !m_tvalid || m_tready;
  assign after_pfx  = (pads != 6'd0) ? ST_PAD : ST_DIGIT;
  assign after_sign = (alt && (bsel == BaseHex || (bsel == BaseOct && nonzero)))
                      ? ST_PFX0 : after_pfx;
  assign need       = {1'b0, ndig} + {5'd0, has_sign};

  always_comb begin
    state_next  = state;
    feed_load   = 1'b0;
    feed_shift  = 1'b0;
    chain_clear = 1'b0;
    bit_shift   = 1'b0;
    digit_shift = 1'b0;
    m_load      = 1'b0;
    m_char      = ChZero;
    m_last      = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          feed_load   = 1'b1;
          chain_clear = 1'b1;
          state_next  = ST_CONV;
        end
      end
      ST_CONV: begin
        feed_shift = 1'b1;
        bit_shift  = 1'b1;
        if (feed_last) state_next = ST_ALIGN;
      end
      ST_ALIGN: begin
        // drop leading zero digits, keep at least one
        if (cell_top == 4'd0 && ndig > 5'd1) begin
          digit_shift = 1'b1;
        end else begin
          state_next = ST_SIGN;
        end
      end
      ST_SIGN: begin
        if (!has_sign || out_free) begin
          m_load     = has_sign;
          m_char     = sign_ch;
          state_next = after_sign;
        end
      end
      ST_PFX0: begin
        if (out_free) begin
          m_load     = 1'b1;
          m_char     = ChZero;
          state_next = (bsel == BaseHex) ? ST_PFXX : after_pfx;
        end
      end
      ST_PFXX: begin
        if (out_free) begin
          m_load     = 1'b1;
          m_char     = ChX;
          state_next = after_pfx;
        end
      end
      ST_PAD: begin
        if (out_free) begin
          m_load = 1'b1;
          m_char = ChZero;
          if (pads == 6'd1) state_next = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        if (out_free) begin
          m_load      = 1'b1;
          m_char      = digit_char(cell_top, upper);
          digit_shift = 1'b1;
          if (ndig == 5'd1) begin
            m_last     = 1'b1;
            state_next = ST_IDLE;
          end
        end
      end
    endcase
  end

  // state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (m_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  // captured options and counters
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && s_tvalid) begin
      bsel     <= in_bsel;
      upper    <= s_tdata[68];
      alt      <= s_tdata[69];
      nonzero  <= (in_val != '0);
      prec     <= in_prec;
      ndig     <= 5'(NumCells);
      has_sign <= in_neg || (in_dec && (s_tdata[70] || s_tdata[71]));
      sign_ch  <= in_neg ? ChMinus : s_tdata[70] ? ChPlus : ChBlank;
    end else if (digit_shift) begin
      ndig <= ndig - 5'd1;
    end
    // pads counted against sign plus digits
    if (state == ST_ALIGN && !digit_shift) begin
      pads <= (prec > need) ? prec - need : 6'd0;
    end else if (m_load && state == ST_PAD) begin
      pads <= pads - 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (m_load) begin
      m_tdata <= m_char;
      m_tlast <= m_last;
    end
  end

  assign s_tready = (state == ST_IDLE);

`ifndef ASSERT_OFF
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !s_tready) else $error("accept while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
    else $error("output changed while waiting");
  a_chain_no_overflow: assert property (@(posedge clk) disable iff (rst)
    bit_shift |-> !cell_c[NumCells-1]) else $error("digit chain overflow");
  a_digit_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIGIT) |-> (ndig != 5'd0)) else $error("digit count empty");
`endif
endmodule
